>>> rtl/hcbd_pkg.sv
`default_nettype none

package hcbd_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  localparam logic [1:0] KIND_FRAMING  = 2'd0;
  localparam logic [1:0] KIND_DATA     = 2'd1;
  localparam logic [1:0] KIND_AFTER_END = 2'd2;

  typedef enum logic [3:0] {
    PH_SIZE  = 4'b0001,
    PH_DATA  = 4'b0010,
    PH_AFTER = 4'b0100,
    PH_END   = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    SC_BLANK  = 3'b001,
    SC_DIGITS = 3'b010,
    SC_DONE   = 3'b100
  } scan_t;

  typedef struct packed {
    scan_t scan;
    logic  sat;
  } line_ctl_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       chunk_last;
    logic       message_end;
  } result_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
      [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
      [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF);
  endfunction

endpackage

`default_nettype wire

>>> rtl/hcbd_if.sv
`default_nettype none

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_message;
  logic       last_in_read;

  modport source (output valid, in_byte, new_message, last_in_read, input ready);
  modport sink (input valid, in_byte, new_message, last_in_read, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_data;
  logic       chunk_last;
  logic       message_end;
  logic       read_end;

  modport source (output valid, kind, out_data, chunk_last, message_end, read_end,
                  input ready);
  modport sink (input valid, kind, out_data, chunk_last, message_end, read_end,
                output ready);
endinterface

`default_nettype wire

>>> rtl/hcbd_line.sv
`default_nettype none

module hcbd_line #(
  parameter int SIZE_BITS = 32,
  parameter int LINE_KEEP = 31
) (
  input  wire logic [7:0]                  c,
  input  wire logic [SIZE_BITS-1:0]        accum,
  input  wire logic [$clog2(LINE_KEEP+1)-1:0] kept,
  input  wire hcbd_pkg::line_ctl_t         ctl,
  output logic [SIZE_BITS-1:0]             accum_next,
  output logic [$clog2(LINE_KEEP+1)-1:0]   kept_next,
  output hcbd_pkg::line_ctl_t              ctl_next,
  output logic                             line_end,
  output logic                             size_zero
);

  localparam int KW = $clog2(LINE_KEEP + 1);

  logic [4:0] hex;

  assign hex       = hcbd_pkg::hex_value(c);
  assign line_end  = (c == hcbd_pkg::CH_LF);
  assign size_zero = (accum == '0);

  always_comb begin
    accum_next = accum;
    kept_next  = kept;
    ctl_next   = ctl;
    if (line_end) begin
      accum_next    = '0;
      kept_next     = '0;
      ctl_next.scan = hcbd_pkg::SC_BLANK;
      ctl_next.sat  = 1'b0;
    end else if (c != hcbd_pkg::CH_CR && kept < KW'(LINE_KEEP)) begin
      kept_next = kept + 1'b1;
      if (ctl.scan == hcbd_pkg::SC_DONE) begin
        ctl_next = ctl;
      end else if (ctl.scan == hcbd_pkg::SC_BLANK && hcbd_pkg::is_blank(c)) begin
        ctl_next = ctl;
      end else if (!hex[4]) begin
        ctl_next.scan = hcbd_pkg::SC_DONE;
      end else begin
        ctl_next.scan = hcbd_pkg::SC_DIGITS;
        if (!ctl.sat) begin
          if (|accum[SIZE_BITS-1 -: 4]) begin
            accum_next   = '1;
            ctl_next.sat = 1'b1;
          end else begin
            accum_next = {accum[SIZE_BITS-5:0], hex[3:0]};
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/hcbd_decoder.sv
`default_nettype none

module hcbd_decoder #(
  parameter int SIZE_BITS = 32,
  parameter int LINE_KEEP = 31
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        c,
  input  wire logic              new_message,
  output hcbd_pkg::result_t      res
);

  localparam int KW = $clog2(LINE_KEEP + 1);

  hcbd_pkg::phase_t    phase, phase_e, phase_w, phase_next;
  logic [SIZE_BITS-1:0] bytes_left, bl_e, bytes_left_next;
  logic [SIZE_BITS-1:0] size_accum, accum_e, size_accum_next, line_accum;
  logic [KW-1:0]        kept_count, kept_e, kept_count_next, line_kept;
  hcbd_pkg::line_ctl_t  line_ctl, ctl_e, line_ctl_next, line_ctl_out;
  logic                 line_end, size_zero, run_line;

  // new_message clears everything ahead of this byte
  always_comb begin
    if (new_message) begin
      phase_e    = hcbd_pkg::PH_SIZE;
      bl_e       = '0;
      accum_e    = '0;
      kept_e     = '0;
      ctl_e.scan = hcbd_pkg::SC_BLANK;
      ctl_e.sat  = 1'b0;
    end else begin
      phase_e = phase;
      bl_e    = bytes_left;
      accum_e = size_accum;
      kept_e  = kept_count;
      ctl_e   = line_ctl;
    end
  end

  assign phase_w = (phase_e == hcbd_pkg::PH_DATA && bl_e == '0) ? hcbd_pkg::PH_AFTER
                                                                  : phase_e;

  assign run_line = (phase_w == hcbd_pkg::PH_SIZE) ||
                    (phase_w == hcbd_pkg::PH_AFTER && c != hcbd_pkg::CH_CR &&
                     c != hcbd_pkg::CH_LF);

  hcbd_line #(
    .SIZE_BITS (SIZE_BITS),
    .LINE_KEEP (LINE_KEEP)
  ) u_line (
    .c          (c),
    .accum      (accum_e),
    .kept       (kept_e),
    .ctl        (ctl_e),
    .accum_next (line_accum),
    .kept_next  (line_kept),
    .ctl_next   (line_ctl_out),
    .line_end   (line_end),
    .size_zero  (size_zero)
  );

  always_comb begin
    phase_next      = phase_w;
    bytes_left_next = bl_e;
    size_accum_next = accum_e;
    kept_count_next = kept_e;
    line_ctl_next   = ctl_e;
    res.kind        = hcbd_pkg::KIND_FRAMING;
    res.chunk_last  = 1'b0;
    res.message_end = 1'b0;
    unique case (phase_w)
      hcbd_pkg::PH_END: begin
        res.kind = hcbd_pkg::KIND_AFTER_END;
      end
      hcbd_pkg::PH_DATA: begin
        res.kind        = hcbd_pkg::KIND_DATA;
        bytes_left_next = bl_e - 1'b1;
        if (bl_e == SIZE_BITS'(1)) begin
          res.chunk_last = 1'b1;
          phase_next     = hcbd_pkg::PH_AFTER;
        end
      end
      hcbd_pkg::PH_AFTER: begin
        if (c != hcbd_pkg::CH_CR) begin
          phase_next = hcbd_pkg::PH_SIZE;
        end
      end
      default: begin
        phase_next = phase_w;
      end
    endcase
    if (run_line) begin
      size_accum_next = line_accum;
      kept_count_next = line_kept;
      line_ctl_next   = line_ctl_out;
      if (line_end) begin
        if (size_zero) begin
          phase_next      = hcbd_pkg::PH_END;
          res.message_end = 1'b1;
        end else begin
          bytes_left_next = accum_e;
          phase_next      = hcbd_pkg::PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= hcbd_pkg::PH_SIZE;
      bytes_left    <= '0;
      size_accum    <= '0;
      kept_count    <= '0;
      line_ctl.scan <= hcbd_pkg::SC_BLANK;
      line_ctl.sat  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      size_accum <= size_accum_next;
      kept_count <= kept_count_next;
      line_ctl   <= line_ctl_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/http_chunked_body_decoder_top.sv
// HTTP chunked body decoder.
// in_stream carries one body byte per transfer with new_message (clear all
// decoder state before this byte) and last_in_read (end of a network read).
// out_stream carries one result per input byte, in order: kind (framing,
// body data, or not consumed after the terminating zero-size line), the byte
// itself, chunk_last on the final data byte of a chunk, message_end on the LF
// of the zero-size line, and read_end echoing last_in_read.
// Each accepted byte is held in the input register, and its result is stored
// in the output register when the decoder steps. Throughput: one byte per
// cycle while out_stream is ready; the decoder state updates in a single pass
// between the input register and the output register.
// When out_stream stalls, the result holds; in_stream keeps taking bytes until
// the input register is also occupied, then ready drops.
// rst (synchronous, active high) empties both registers and returns the
// decoder to the start of a size line.
`default_nettype none

module http_chunked_body_decoder_top #(
  parameter int SIZE_BITS = 32,
  parameter int LINE_KEEP = 31
) (
  input  wire logic   clk,
  input  wire logic   rst,
  hcbd_in_if.sink     in_stream,
  hcbd_out_if.source  out_stream
);

  logic              in_vld;
  logic [7:0]        in_byte_q;
  logic              new_msg_q;
  logic              read_end_q;
  logic              out_vld;
  logic              fire;
  hcbd_pkg::result_t res;

  assign fire            = in_vld && (!out_vld || out_stream.ready);
  assign in_stream.ready = !in_vld || fire;
  assign out_stream.valid = out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_stream.valid && in_stream.ready) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      in_byte_q  <= in_stream.in_byte;
      new_msg_q  <= in_stream.new_message;
      read_end_q <= in_stream.last_in_read;
    end
  end

  hcbd_decoder #(
    .SIZE_BITS (SIZE_BITS),
    .LINE_KEEP (LINE_KEEP)
  ) u_decoder (
    .clk         (clk),
    .rst         (rst),
    .step        (fire),
    .c           (in_byte_q),
    .new_message (new_msg_q),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire) begin
      out_vld <= 1'b1;
    end else if (out_stream.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_stream.kind        <= res.kind;
      out_stream.out_data    <= in_byte_q;
      out_stream.chunk_last  <= res.chunk_last;
      out_stream.message_end <= res.message_end;
      out_stream.read_end    <= read_end_q;
    end
  end

`ifndef SYNTH
  a_mend_framing: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_stream.message_end |-> out_stream.kind == hcbd_pkg::KIND_FRAMING)
    else $error("message_end on non-framing byte");

  a_last_data: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_stream.chunk_last |-> out_stream.kind == hcbd_pkg::KIND_DATA)
    else $error("chunk_last on non-data byte");

  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_vld)
    else $error("processed byte lost its result");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    in_vld && !fire |=> in_vld)
    else $error("pending input byte dropped");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int          PERIOD       = 4;
  localparam int          LINE_KEEP    = 31;
  localparam logic [31:0] SIZE_ONES    = 32'hFFFF_FFFF;
  localparam int          RANDOM_ITEMS = 1300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          NDIR         = 31;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       chunk_last;
    logic       message_end;
    logic       read_end;
  } outcome_t;

  typedef struct packed {
    logic [7:0] c;
    logic       fresh;
    logic       rd;
    logic       typed;
    logic [1:0] kind;
    logic       chunk_last;
    logic       message_end;
  } stim_row_t;

  // typed rows carry the expected kind, chunk_last and message_end
  localparam stim_row_t DIR_TAB [NDIR] = '{
    '{"1",             1'b1, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{hcbd_pkg::CH_CR, 1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{hcbd_pkg::CH_LF, 1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{8'hFF,           1'b0, 1'b0, 1'b1, hcbd_pkg::KIND_DATA,      1'b1, 1'b0},
    '{"1",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{hcbd_pkg::CH_LF, 1'b0, 1'b1, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{8'h00,           1'b0, 1'b0, 1'b1, hcbd_pkg::KIND_DATA,      1'b1, 1'b0},
    '{hcbd_pkg::CH_CR, 1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{hcbd_pkg::CH_LF, 1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{"-",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{hcbd_pkg::CH_LF, 1'b0, 1'b0, 1'b1, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b1},
    '{8'h00,           1'b0, 1'b1, 1'b1, hcbd_pkg::KIND_AFTER_END, 1'b0, 1'b0},
    '{8'hFF,           1'b0, 1'b0, 1'b1, hcbd_pkg::KIND_AFTER_END, 1'b0, 1'b0},
    '{hcbd_pkg::CH_LF, 1'b1, 1'b0, 1'b1, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b1},
    '{hcbd_pkg::CH_VT, 1'b1, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{hcbd_pkg::CH_FF, 1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{"0",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{"x",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{"1",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{hcbd_pkg::CH_LF, 1'b0, 1'b0, 1'b1, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b1},
    '{"1",             1'b1, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{"0",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{"0",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{"0",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{"0",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{"0",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{"0",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{"0",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{"0",             1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{hcbd_pkg::CH_LF, 1'b0, 1'b0, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0},
    '{8'h5A,           1'b0, 1'b1, 1'b0, hcbd_pkg::KIND_FRAMING,   1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  hcbd_in_if  in_if ();
  hcbd_out_if out_if ();

  http_chunked_body_decoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  always #(PERIOD / 2) clk = ~clk;

  // decoder state mirror
  hcbd_pkg::phase_t st_phase;
  logic [31:0]      st_left;
  logic [31:0]      st_accum;
  hcbd_pkg::scan_t  st_scan;
  logic [5:0]       st_kept;
  bit               st_sat;

  outcome_t    pending_results[$];
  logic [7:0]  msg_bytes[$];
  stim_row_t   typed_row;
  bit          steady;
  int unsigned items_sent;
  int unsigned errors;
  int unsigned cycles = 0;
  int unsigned n_framing, n_data, n_after_end, n_chunk_last, n_msg_end;

  function automatic void clear_line();
    st_accum = '0;
    st_scan  = hcbd_pkg::SC_BLANK;
    st_kept  = '0;
    st_sat   = 1'b0;
  endfunction

  function automatic void restart_decoder();
    st_phase = hcbd_pkg::PH_SIZE;
    st_left  = '0;
    clear_line();
  endfunction

  // one size-line byte; returns 1 when the line closes the message
  function automatic bit size_line_byte(input logic [7:0] c);
    logic [3:0]  nib;
    bit          hex;
    logic [31:0] size;
    if (c == hcbd_pkg::CH_LF) begin
      size = st_accum;
      clear_line();
      if (size == 0) begin
        st_phase = hcbd_pkg::PH_END;
        return 1'b1;
      end
      st_left  = size;
      st_phase = hcbd_pkg::PH_DATA;
      return 1'b0;
    end
    if (c == hcbd_pkg::CH_CR || st_kept >= LINE_KEEP) return 1'b0;
    st_kept = st_kept + 6'd1;
    if (st_scan == hcbd_pkg::SC_DONE) return 1'b0;
    if (st_scan == hcbd_pkg::SC_BLANK &&
        (c == hcbd_pkg::CH_SP || c == hcbd_pkg::CH_HT || c == hcbd_pkg::CH_VT ||
         c == hcbd_pkg::CH_FF)) return 1'b0;
    hex = 1'b1;
    nib = '0;
    if (c >= "0" && c <= "9")      nib = 4'(c - "0");
    else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
    else                           hex = 1'b0;
    if (!hex) begin
      st_scan = hcbd_pkg::SC_DONE;
      return 1'b0;
    end
    st_scan = hcbd_pkg::SC_DIGITS;
    if (st_sat) return 1'b0;
    if (st_accum > (SIZE_ONES >> 4)) begin
      st_accum = SIZE_ONES;
      st_sat   = 1'b1;
    end else begin
      st_accum = {st_accum[27:0], nib};
    end
    return 1'b0;
  endfunction

  function automatic outcome_t decode_byte(input logic [7:0] c, input logic fresh,
                                           input logic rd);
    outcome_t r;
    r.kind        = hcbd_pkg::KIND_FRAMING;
    r.data        = c;
    r.chunk_last  = 1'b0;
    r.message_end = 1'b0;
    r.read_end    = rd;
    if (fresh) restart_decoder();
    if (st_phase == hcbd_pkg::PH_DATA && st_left == 0) st_phase = hcbd_pkg::PH_AFTER;
    case (st_phase)
      hcbd_pkg::PH_END: begin
        r.kind = hcbd_pkg::KIND_AFTER_END;
      end
      hcbd_pkg::PH_DATA: begin
        r.kind  = hcbd_pkg::KIND_DATA;
        st_left = st_left - 1;
        if (st_left == 0) begin
          r.chunk_last = 1'b1;
          st_phase     = hcbd_pkg::PH_AFTER;
        end
      end
      hcbd_pkg::PH_AFTER: begin
        if (c == hcbd_pkg::CH_LF) begin
          st_phase = hcbd_pkg::PH_SIZE;
        end else if (c != hcbd_pkg::CH_CR) begin
          st_phase      = hcbd_pkg::PH_SIZE;
          r.message_end = size_line_byte(c);
        end
      end
      default: begin
        r.message_end = size_line_byte(c);
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    if (steady) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic send_byte(input stim_row_t row);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.in_byte      <= row.c;
    in_if.new_message  <= row.fresh;
    in_if.last_in_read <= row.rd;
    typed_row          <= row;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic add_size_line(input logic [31:0] size);
    int         i;
    int         n;
    bit         started;
    logic [3:0] nib;
    logic [7:0] c;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 2);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       c = hcbd_pkg::CH_SP;
        1:       c = hcbd_pkg::CH_HT;
        2:       c = hcbd_pkg::CH_VT;
        default: c = hcbd_pkg::CH_FF;
      endcase
      msg_bytes.push_back(c);
    end
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) msg_bytes.push_back("0");
    started = 1'b0;
    for (i = 7; i >= 0; i--) begin
      nib = size[4*i +: 4];
      if (nib != 0 || started || i == 0) begin
        started = 1'b1;
        if (nib < 10) c = 8'(8'h30 + nib);
        else c = 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10);
        msg_bytes.push_back(c);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      msg_bytes.push_back(";");
      n = $urandom_range(0, 6);
      repeat (n) msg_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
    if ($urandom_range(0, 4) != 0) msg_bytes.push_back(hcbd_pkg::CH_CR);
    msg_bytes.push_back(hcbd_pkg::CH_LF);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // input transfer: predict
  always @(posedge clk) begin : accept_side
    outcome_t want;
    if (!rst && in_if.valid && in_if.ready) begin
      want = decode_byte(in_if.in_byte, in_if.new_message, in_if.last_in_read);
      if (typed_row.typed) begin
        want.kind        = typed_row.kind;
        want.chunk_last  = typed_row.chunk_last;
        want.message_end = typed_row.message_end;
      end
      pending_results.push_back(want);
    end
  end

  // output transfer: check
  always @(posedge clk) begin : result_side
    outcome_t want;
    outcome_t got;
    if (!rst && out_if.valid && out_if.ready) begin
      got.kind        = out_if.kind;
      got.data        = out_if.out_data;
      got.chunk_last  = out_if.chunk_last;
      got.message_end = out_if.message_end;
      got.read_end    = out_if.read_end;
      case (got.kind)
        hcbd_pkg::KIND_DATA:      n_data++;
        hcbd_pkg::KIND_AFTER_END: n_after_end++;
        default:                  n_framing++;
      endcase
      if (got.chunk_last)  n_chunk_last++;
      if (got.message_end) n_msg_end++;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result: kind %0d data %02h", got.kind, got.data));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.data !== want.data ||
            got.chunk_last !== want.chunk_last || got.message_end !== want.message_end ||
            got.read_end !== want.read_end)
          note_error($sformatf(
            "mismatch: want kind %0d data %02h last %0b end %0b read %0b, got %0d %02h %0b %0b %0b",
            want.kind, want.data, want.chunk_last, want.message_end, want.read_end,
            got.kind, got.data, got.chunk_last, got.message_end, got.read_end));
      end
    end
  end

  initial begin : sink
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int        i;
    int        k;
    int        nchunks;
    int        n;
    bit        noise;
    int        sz;
    stim_row_t row;
    in_if.valid        <= 1'b0;
    in_if.in_byte      <= '0;
    in_if.new_message  <= 1'b0;
    in_if.last_in_read <= 1'b0;
    typed_row          <= '0;
    steady     = 1'b0;
    items_sent = 0;
    errors     = 0;
    restart_decoder();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < NDIR; i++) send_byte(DIR_TAB[i]);

    while (items_sent < NDIR + RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 5) == 0);
      msg_bytes.delete();
      noise  = ($urandom_range(0, 9) == 0);
      if (noise) begin
        n = $urandom_range(1, 12);
        repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        nchunks = $urandom_range(0, 3);
        for (k = 0; k < nchunks; k++) begin
          sz = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 16);
          add_size_line(32'(sz));
          repeat (sz) msg_bytes.push_back(8'($urandom_range(0, 255)));
          case ($urandom_range(0, 5))
            0: ;
            1: msg_bytes.push_back(hcbd_pkg::CH_LF);
            default: begin
              msg_bytes.push_back(hcbd_pkg::CH_CR);
              msg_bytes.push_back(hcbd_pkg::CH_LF);
            end
          endcase
        end
        add_size_line('0);
        n = $urandom_range(0, 3);
        repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
      for (i = 0; i < msg_bytes.size(); i++) begin
        row       = '0;
        row.c     = msg_bytes[i];
        if (i == 0) row.fresh = noise ? 1'($urandom_range(0, 1)) : 1'b1;
        else        row.fresh = ($urandom_range(0, 199) == 0);
        if (i == msg_bytes.size() - 1) row.rd = 1'($urandom_range(0, 1));
        else                           row.rd = ($urandom_range(0, 7) == 0);
        send_byte(row);
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes over directed and random chunked messages in %0d cycles.",
             items_sent, cycles);
    $display("Results: %0d framing, %0d data (%0d chunk ends), %0d after end, %0d ends.",
             n_framing, n_data, n_chunk_last, n_after_end, n_msg_end);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
